FILE: hw/rtl/pend_pkg.sv
// Shared constants, types and saturation helper for the pendulum integrator.
package pend_pkg;

  localparam int StateW    = 32;
  localparam int InnerW    = 56;
  localparam int SumW      = InnerW + 3;
  localparam int WideW     = 64;
  localparam int MulDigitW = 4;
  localparam int MulSteps  = 32 / MulDigitW;
  localparam int MulCntW   = $clog2(MulSteps);
  localparam int DivSteps  = WideW;
  localparam int DivCntW   = $clog2(DivSteps);

  localparam logic [WideW-1:0]   ProdLimit    = 64'h4000_0000_0000_0000;
  localparam logic [3:0]         DivSix       = 4'd6;
  localparam logic [31:0]        TimeStepRst  = 32'd429497;
  localparam logic [30:0]        OmegaSqRst   = 31'd164584489;
  localparam logic signed [31:0] InitAngleRst = 32'sd1677722;
  localparam logic               MethodRst    = 1'b1;

  typedef enum logic [1:0] {
    SH_24,
    SH_32,
    SH_33
  } shift_t;

  typedef struct packed {
    logic signed [WideW-1:0] res;
    logic [WideW-2:0]        mag;
    logic                    neg;
    logic                    clip;
  } mul_res_t;

  typedef struct packed {
    logic                    clip;
    logic signed [WideW-1:0] val;
  } sat_t;

  function automatic sat_t sat_to(input logic signed [WideW-1:0] v, input int bits);
    logic signed [WideW-1:0] hi;
    logic signed [WideW-1:0] lo;
    sat_t r;
    hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    r.clip = 1'b1;
    if (v > hi) begin
      r.val = hi;
    end else if (v < lo) begin
      r.val = lo;
    end else begin
      r.val = v;
      r.clip = 1'b0;
    end
    return r;
  endfunction

  localparam sat_t AngleRstSat = sat_to(64'(InitAngleRst), StateW);

endpackage

FILE: hw/rtl/pend_mul.sv
// Digit-serial signed-by-unsigned multiplier with floored shift and product clamp.
module pend_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [pend_pkg::WideW-1:0] a,
  input  logic [31:0]                       b,
  input  pend_pkg::shift_t                  sh,
  output logic                              done,
  output pend_pkg::mul_res_t                res
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_RUN,
    M_FIN1,
    M_FIN2
  } mstate_t;

  localparam int PpW = pend_pkg::WideW + pend_pkg::MulDigitW;
  localparam int QW  = pend_pkg::WideW + 1;

  mstate_t                         state_r;
  logic [pend_pkg::WideW-1:0]      m_r;
  logic [31:0]                     b_r;
  logic [pend_pkg::WideW-1:0]      acc_r;
  logic [31:0]                     lo_r;
  logic                            neg_r;
  pend_pkg::shift_t                sh_r;
  logic [pend_pkg::MulCntW-1:0]    cnt_r;
  logic [QW-1:0]                   q_r;
  logic                            clip_r;
  logic                            done_r;
  pend_pkg::mul_res_t              res_r;

  logic [PpW-1:0]                  pp;
  logic [QW-1:0]                   qraw;
  logic [QW-1:0]                   qinc;
  logic                            rem;
  logic                            ovf;
  logic                            big;
  logic [pend_pkg::WideW-2:0]      magv;

  assign pp = {pend_pkg::MulDigitW'(0), acc_r}
            + (PpW'(m_r) * PpW'(b_r[pend_pkg::MulDigitW-1:0]));

  always_comb begin
    ovf = 1'b0;
    case (sh_r)
      pend_pkg::SH_24: begin
        ovf  = |acc_r[63:54];
        qraw = {3'b0, acc_r[53:0], lo_r[31:24]};
        rem  = |lo_r[23:0];
      end
      pend_pkg::SH_33: begin
        qraw = {2'b0, acc_r[63:1]};
        rem  = (|lo_r) | acc_r[0];
      end
      default: begin
        qraw = {1'b0, acc_r};
        rem  = |lo_r;
      end
    endcase
    qinc = qraw + QW'(rem & neg_r);
  end

  assign big  = q_r > QW'(pend_pkg::ProdLimit);
  assign magv = big ? pend_pkg::ProdLimit[pend_pkg::WideW-2:0] : q_r[pend_pkg::WideW-2:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (start) begin
            neg_r   <= a[pend_pkg::WideW-1];
            m_r     <= a[pend_pkg::WideW-1] ? -a : a;
            b_r     <= b;
            sh_r    <= sh;
            acc_r   <= '0;
            lo_r    <= '0;
            cnt_r   <= '0;
            state_r <= M_RUN;
          end
        end
        M_RUN: begin
          acc_r <= pp[PpW-1:pend_pkg::MulDigitW];
          lo_r  <= {pp[pend_pkg::MulDigitW-1:0], lo_r[31:pend_pkg::MulDigitW]};
          b_r   <= b_r >> pend_pkg::MulDigitW;
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == pend_pkg::MulCntW'(pend_pkg::MulSteps - 1)) begin
            state_r <= M_FIN1;
          end
        end
        M_FIN1: begin
          q_r     <= ovf ? QW'(pend_pkg::ProdLimit) : qinc;
          clip_r  <= ovf;
          state_r <= M_FIN2;
        end
        M_FIN2: begin
          res_r.mag  <= magv;
          res_r.neg  <= neg_r;
          res_r.clip <= clip_r | big;
          res_r.res  <= neg_r ? -{1'b0, magv} : {1'b0, magv};
          done_r     <= 1'b1;
          state_r    <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

FILE: hw/rtl/pend_div6.sv
// Bit-serial floor division of a signed magnitude by six.
module pend_div6 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [pend_pkg::WideW-2:0]        mag,
  input  logic                              neg,
  output logic                              done,
  output logic signed [pend_pkg::WideW-1:0] quo
);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIN
  } dstate_t;

  dstate_t                           state_r;
  logic [pend_pkg::WideW-1:0]        n_r;
  logic [2:0]                        r_r;
  logic [pend_pkg::DivCntW-1:0]      cnt_r;
  logic                              neg_r;
  logic                              done_r;
  logic signed [pend_pkg::WideW-1:0] quo_r;

  logic [3:0] t;
  logic       ge;
  logic [3:0] tsub;

  assign t    = {r_r, n_r[pend_pkg::WideW-1]};
  assign ge   = t >= pend_pkg::DivSix;
  assign tsub = t - pend_pkg::DivSix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            // negative values round toward minus infinity
            n_r     <= {1'b0, mag} + (neg ? 64'd5 : 64'd0);
            neg_r   <= neg;
            r_r     <= '0;
            cnt_r   <= '0;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          r_r   <= ge ? tsub[2:0] : t[2:0];
          n_r   <= {n_r[pend_pkg::WideW-2:0], ge};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == pend_pkg::DivCntW'(pend_pkg::DivSteps - 1)) begin
            state_r <= D_FIN;
          end
        end
        D_FIN: begin
          quo_r   <= neg_r ? -n_r : n_r;
          done_r  <= 1'b1;
          state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

FILE: hw/rtl/pendulum_rk4_euler_integrator.sv
// Top level: linearized pendulum integrator, Euler or RK4, step sequencer.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    in_restart
//   out      out_valid / out_ready  out_angle, out_angular_velocity, out_saturated
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An RK4 step makes twelve passes through the 4-bit-digit multiplier and two
// bit-serial divides by six. One word is in flight at a time; a new word
// is taken while the previous result waits in the output register.
// Reset is synchronous; cfg_ready is always high.
module pendulum_rk4_euler_integrator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_angle,
  output logic signed [31:0] out_angular_velocity,
  output logic               out_saturated,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [2:0] {
    T_IDLE,
    T_ISSUE,
    T_WAIT,
    T_SUM,
    T_DIV,
    T_DONE
  } tstate_t;

  typedef enum logic [2:0] {
    OP_ACC,
    OP_XS,
    OP_VS,
    OP_FA,
    OP_FV,
    OP_EA,
    OP_EV
  } op_t;

  typedef enum logic [1:0] {
    CFG_TIME_STEP,
    CFG_OMEGA_SQ,
    CFG_INIT_ANGLE,
    CFG_METHOD
  } cfg_idx_t;

  localparam logic METHOD_EULER = 1'b0;

  localparam int SW = pend_pkg::StateW;
  localparam int IW = pend_pkg::InnerW;
  localparam int UW = pend_pkg::SumW;
  localparam int WW = pend_pkg::WideW;

  tstate_t               state_r;
  op_t                   op_r;
  logic [31:0]           time_step_r;
  logic [30:0]           omega_sq_r;
  logic signed [31:0]    init_angle_r;
  logic                  method_r;
  logic signed [SW-1:0]  x_r;
  logic signed [SW-1:0]  v_r;
  logic signed [SW-1:0]  nx_r;
  logic signed [IW-1:0]  sx_r;
  logic signed [IW-1:0]  sv_r;
  logic signed [IW-1:0]  kv_r;
  logic signed [UW-1:0]  suma_r;
  logic signed [UW-1:0]  sumv_r;
  logic [1:0]            st_r;
  logic                  flag_r;
  logic                  out_valid_r;
  logic signed [31:0]    out_angle_r;
  logic signed [31:0]    out_vel_r;
  logic                  out_sat_r;

  logic                  mul_start;
  logic signed [WW-1:0]  mul_a;
  logic [31:0]           mul_b;
  pend_pkg::shift_t      mul_sh;
  logic                  mul_done;
  pend_pkg::mul_res_t    mul_res;
  logic                  div_start;
  logic                  div_done;
  logic signed [WW-1:0]  div_quo;

  logic signed [WW-1:0]  add_src;
  logic signed [WW-1:0]  x_sum;
  logic signed [WW-1:0]  v_sum;
  pend_pkg::sat_t        xi;
  pend_pkg::sat_t        vi;
  pend_pkg::sat_t        xs;
  pend_pkg::sat_t        vs;
  pend_pkg::sat_t        ki;
  pend_pkg::sat_t        rs;
  logic                  post_clip;
  logic                  w2;

  always_comb begin
    mul_b  = time_step_r;
    mul_sh = pend_pkg::SH_32;
    case (op_r)
      OP_ACC: begin
        mul_a  = -WW'(sx_r);
        mul_b  = {1'b0, omega_sq_r};
        mul_sh = pend_pkg::SH_24;
      end
      OP_XS: begin
        mul_a  = WW'(sv_r);
        mul_sh = (st_r < 2'd2) ? pend_pkg::SH_33 : pend_pkg::SH_32;
      end
      OP_VS: begin
        mul_a  = WW'(kv_r);
        mul_sh = (st_r < 2'd2) ? pend_pkg::SH_33 : pend_pkg::SH_32;
      end
      OP_FA:   mul_a = WW'(suma_r);
      OP_FV:   mul_a = WW'(sumv_r);
      OP_EA:   mul_a = WW'(v_r);
      OP_EV:   mul_a = WW'(kv_r);
      default: mul_a = '0;
    endcase
  end

  assign mul_start = state_r == T_ISSUE;
  assign div_start = (state_r == T_WAIT) && mul_done && ((op_r == OP_FA) || (op_r == OP_FV));

  assign add_src = (state_r == T_DIV) ? div_quo : mul_res.res;
  assign x_sum   = WW'(x_r) + add_src;
  assign v_sum   = WW'(v_r) + add_src;
  assign xi      = pend_pkg::sat_to(x_sum, IW);
  assign vi      = pend_pkg::sat_to(v_sum, IW);
  assign xs      = pend_pkg::sat_to(x_sum, SW);
  assign vs      = pend_pkg::sat_to(v_sum, SW);
  assign ki      = pend_pkg::sat_to(mul_res.res, IW);
  assign rs      = pend_pkg::sat_to(WW'(init_angle_r), SW);
  assign w2      = (st_r == 2'd1) || (st_r == 2'd2);

  always_comb begin
    case (op_r)
      OP_ACC:  post_clip = ki.clip;
      OP_XS:   post_clip = xi.clip;
      OP_VS:   post_clip = vi.clip;
      OP_EA:   post_clip = xs.clip;
      OP_EV:   post_clip = vs.clip;
      default: post_clip = 1'b0;
    endcase
  end

  pend_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh    (mul_sh),
    .done  (mul_done),
    .res   (mul_res)
  );

  pend_div6 u_div6 (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (mul_res.mag),
    .neg   (mul_res.neg),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= T_IDLE;
      op_r         <= OP_ACC;
      out_valid_r  <= 1'b0;
      time_step_r  <= pend_pkg::TimeStepRst;
      omega_sq_r   <= pend_pkg::OmegaSqRst;
      init_angle_r <= pend_pkg::InitAngleRst;
      method_r     <= pend_pkg::MethodRst;
      x_r          <= pend_pkg::AngleRstSat.val[SW-1:0];
      v_r          <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TIME_STEP:  time_step_r  <= cfg_data;
          CFG_OMEGA_SQ:   omega_sq_r   <= cfg_data[30:0];
          CFG_INIT_ANGLE: init_angle_r <= cfg_data;
          CFG_METHOD:     method_r     <= cfg_data[0];
          default: ;
        endcase
      end

      // a word loaded in T_DONE keeps the output valid
      if (out_valid_r && out_ready && (state_r != T_DONE)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        T_IDLE: begin
          if (in_valid) begin
            sx_r   <= IW'(x_r);
            sv_r   <= IW'(v_r);
            suma_r <= '0;
            sumv_r <= '0;
            st_r   <= '0;
            op_r   <= OP_ACC;
            if (in_restart) begin
              x_r     <= rs.val[SW-1:0];
              v_r     <= '0;
              flag_r  <= rs.clip;
              state_r <= T_DONE;
            end else begin
              flag_r  <= 1'b0;
              state_r <= T_ISSUE;
            end
          end
        end
        T_ISSUE: state_r <= T_WAIT;
        T_WAIT: begin
          if (mul_done) begin
            flag_r <= flag_r | mul_res.clip | post_clip;
            case (op_r)
              OP_ACC: begin
                kv_r    <= ki.val[IW-1:0];
                state_r <= T_SUM;
              end
              OP_XS: begin
                sx_r    <= xi.val[IW-1:0];
                op_r    <= OP_VS;
                state_r <= T_ISSUE;
              end
              OP_VS: begin
                sv_r    <= vi.val[IW-1:0];
                st_r    <= st_r + 1'b1;
                op_r    <= OP_ACC;
                state_r <= T_ISSUE;
              end
              OP_EA: begin
                nx_r    <= xs.val[SW-1:0];
                op_r    <= OP_EV;
                state_r <= T_ISSUE;
              end
              OP_EV: begin
                v_r     <= vs.val[SW-1:0];
                x_r     <= nx_r;
                state_r <= T_DONE;
              end
              default: state_r <= T_DIV;
            endcase
          end
        end
        T_SUM: begin
          // RK4 weights 1, 2, 2, 1
          suma_r <= suma_r + (w2 ? (UW'(sv_r) <<< 1) : UW'(sv_r));
          sumv_r <= sumv_r + (w2 ? (UW'(kv_r) <<< 1) : UW'(kv_r));
          if (method_r == METHOD_EULER) begin
            op_r <= OP_EA;
          end else if (st_r == 2'd3) begin
            op_r <= OP_FA;
          end else begin
            op_r <= OP_XS;
          end
          state_r <= T_ISSUE;
        end
        T_DIV: begin
          if (div_done) begin
            if (op_r == OP_FA) begin
              nx_r    <= xs.val[SW-1:0];
              flag_r  <= flag_r | xs.clip;
              op_r    <= OP_FV;
              state_r <= T_ISSUE;
            end else begin
              v_r     <= vs.val[SW-1:0];
              x_r     <= nx_r;
              flag_r  <= flag_r | vs.clip;
              state_r <= T_DONE;
            end
          end
        end
        T_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_angle_r <= 32'(x_r);
            out_vel_r   <= 32'(v_r);
            out_sat_r   <= flag_r;
            out_valid_r <= 1'b1;
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign in_ready             = state_r == T_IDLE;
  assign cfg_ready            = 1'b1;
  assign out_valid            = out_valid_r;
  assign out_angle            = out_angle_r;
  assign out_angular_velocity = out_vel_r;
  assign out_saturated        = out_sat_r;

endmodule
